// ----- hdl/aip_pkg.sv -----
// Package for the ASCII integer parser: widths, register indexes, parse phases,
// numeric limits and the character classification functions.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package aip_pkg;

   // Width of the internal character counter; the result count saturates at 16 bits.
   localparam int CountBits  = 16;
   localparam int ResultCountBits = 16;
   localparam int BaseBits   = 6;
   localparam int DigitBits  = 6;
   localparam int ValueBits  = 64;
   localparam int CsrIndexBits = 1;
   localparam int CsrDataBits  = 6;
   // Product of the accumulator and a base below 64, plus one digit.
   localparam int ProductBits = ValueBits + BaseBits;

   typedef logic [CountBits-1:0]       count_type;
   typedef logic [ResultCountBits-1:0] result_count_type;
   typedef logic [BaseBits-1:0]        base_type;
   typedef logic [DigitBits-1:0]       digit_type;
   typedef logic [ValueBits-1:0]       value_type;
   typedef logic [ProductBits-1:0]     product_type;
   typedef logic [CsrDataBits-1:0]     csr_data_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_NUMBER_BASE = 1'b0,
      CSR_SIGNED_MODE = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_LEAD   = 5'b00010,
      PH_SIGNED = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   localparam count_type CountMax = {CountBits{1'b1}};
   localparam base_type  BaseReset = BaseBits'(10);
   localparam base_type  BaseOctal = BaseBits'(8);
   localparam base_type  BaseDecimal = BaseBits'(10);
   localparam base_type  BaseHex   = BaseBits'(16);
   localparam base_type  BaseMin   = BaseBits'(2);
   localparam base_type  BaseMax   = BaseBits'(36);
   localparam digit_type DigitNone = {DigitBits{1'b1}};

   localparam value_type U64Max    = {ValueBits{1'b1}};
   localparam value_type S64Max    = {1'b0, {(ValueBits-1){1'b1}}};
   localparam value_type S64MinMag = {1'b1, {(ValueBits-1){1'b0}}};

   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChUpA   = 8'h41;
   localparam logic [7:0] ChUpZ   = 8'h5A;
   localparam logic [7:0] ChLowA  = 8'h61;
   localparam logic [7:0] ChLowZ  = 8'h7A;
   localparam logic [7:0] ChUpOff = 8'h37;  // 'A' - 10
   localparam logic [7:0] ChLowOff = 8'h57; // 'a' - 10
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChUpX   = 8'h58;
   localparam logic [7:0] ChLowX  = 8'h78;

   // Digit value of a character in any base up to 36, or DigitNone.
   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      d = DigitNone;
      if (c >= ChZero && c <= ChNine) begin
         d = DigitBits'(c - ChZero);
      end else if (c >= ChUpA && c <= ChUpZ) begin
         d = DigitBits'(c - ChUpOff);
      end else if (c >= ChLowA && c <= ChLowZ) begin
         d = DigitBits'(c - ChLowOff);
      end
      return d;
   endfunction

   // Space, tab, line feed, vertical tab, form feed and carriage return.
   function automatic logic is_space(input logic [7:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/aip_channels.sv -----
// Valid/ready channel interfaces of the ASCII integer parser: character requests,
// parse results and register writes. Depends on aip_pkg.
`default_nettype none

interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);
endinterface

interface aip_rsp_if;
   logic                             valid;
   logic                             ready;
   aip_pkg::value_type               value;
   logic                             overflow;
   logic                             digits_seen;
   aip_pkg::result_count_type        consumed_count;

   modport source (output valid, output value, output overflow, output digits_seen,
                   output consumed_count, input ready);
   modport sink   (input valid, input value, input overflow, input digits_seen,
                   input consumed_count, output ready);
endinterface

interface aip_csr_if;
   logic                             valid;
   logic                             ready;
   logic [aip_pkg::CsrIndexBits-1:0] index;
   aip_pkg::csr_data_type            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ascii_integer_parser.sv -----
// Streaming integer-literal parser with strtoull / strtoll behavior, one character per request.
// Between input and result registers a 64x6 multiply-add and limit compare set the path.
// Throughput: one character per cycle unless a held result stalls the parse step.
// Reset (synchronous, active high): number_base 10, unsigned mode, parser idle, no result.
// Depends on aip_pkg and the channel interfaces in aip_channels.sv.
`default_nettype none

module ascii_integer_parser (
   input  wire           clock,
   input  wire           reset,
   aip_req_if.sink       req_ch,
   aip_rsp_if.source     rsp_ch,
   aip_csr_if.sink       csr_ch
);

   // Configuration registers. The user ensures they are written only while the parser is idle.
   aip_pkg::base_type number_base_ff;
   logic              signed_mode_ff;

   // Input register: one accepted character waits here for the parse step.
   logic       s1_valid_ff;
   logic [7:0] s1_ch_ff;
   logic       s1_first_ff;

   // Parser state, updated once per character as it leaves the input register.
   aip_pkg::phase_type  phase_ff,     phase_in;
   aip_pkg::value_type  acc_ff,       acc_in;
   logic                neg_ff,       neg_in;
   aip_pkg::base_type   base_ff,      base_in;
   aip_pkg::count_type  count_ff,     count_in;
   logic                any_digit_ff, any_digit_in;
   logic                ovf_ff,       ovf_in;

   // Result register.
   logic                      rsp_valid_ff;
   aip_pkg::value_type        rsp_value_ff,    rsp_value_in;
   logic                      rsp_ovf_ff;
   logic                      rsp_digits_ff;
   aip_pkg::result_count_type rsp_count_ff,    rsp_count_in;

   logic                 advance;
   logic                 emit;
   logic                 do_lead;
   logic                 do_digit;
   aip_pkg::digit_type   digit;
   aip_pkg::value_type   limit;
   aip_pkg::product_type product;

   // The parse step runs when the result register is free to take whatever it yields.
   // Characters that produce no result also wait on a stalled result, which keeps the
   // control simple and still allows one character per cycle while results drain.
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= aip_pkg::BaseReset;
         signed_mode_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            aip_pkg::CSR_NUMBER_BASE: number_base_ff <= csr_ch.data;
            aip_pkg::CSR_SIGNED_MODE: signed_mode_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_ch_ff    <= req_ch.ch;
         s1_first_ff <= req_ch.first;
      end
   end

   // The parse step. A first flag restarts the string before the character is looked at.
   // A leading '0' in base 0 or 16 moves to PH_ZERO, which decides between an 0x prefix
   // and an octal or hex number. After the prefix, PH_DIGITS is entered with the digit
   // flag cleared, so a bare "0x" ends with no digits and a zero count.
   // The range check uses the full product: acc * base + digit exceeds the limit exactly
   // when the classic cutoff and cutlim test fails, since the digit is below the base.
   always_comb begin
      phase_in     = s1_first_ff ? aip_pkg::PH_LEAD : phase_ff;
      acc_in       = s1_first_ff ? '0 : acc_ff;
      neg_in       = s1_first_ff ? 1'b0 : neg_ff;
      base_in      = s1_first_ff ? '0 : base_ff;
      count_in     = s1_first_ff ? '0 : count_ff;
      any_digit_in = s1_first_ff ? 1'b0 : any_digit_ff;
      ovf_in       = s1_first_ff ? 1'b0 : ovf_ff;
      emit         = 1'b0;
      do_lead      = 1'b0;
      do_digit     = 1'b0;
      digit        = aip_pkg::digit_of(s1_ch_ff);
      limit        = aip_pkg::U64Max;
      product      = '0;

      unique case (phase_in)
         aip_pkg::PH_LEAD: begin
            if (aip_pkg::is_space(s1_ch_ff)) begin
               if (count_in != aip_pkg::CountMax) count_in = count_in + 1'b1;
            end else if (s1_ch_ff == aip_pkg::ChMinus || s1_ch_ff == aip_pkg::ChPlus) begin
               neg_in   = (s1_ch_ff == aip_pkg::ChMinus);
               if (count_in != aip_pkg::CountMax) count_in = count_in + 1'b1;
               phase_in = aip_pkg::PH_SIGNED;
            end else begin
               do_lead = 1'b1;
            end
         end
         aip_pkg::PH_SIGNED: do_lead = 1'b1;
         aip_pkg::PH_ZERO: begin
            if (s1_ch_ff == aip_pkg::ChLowX || s1_ch_ff == aip_pkg::ChUpX) begin
               base_in      = aip_pkg::BaseHex;
               any_digit_in = 1'b0;
               if (count_in != aip_pkg::CountMax) count_in = count_in + 1'b1;
               phase_in     = aip_pkg::PH_DIGITS;
            end else begin
               do_digit = 1'b1;
            end
         end
         aip_pkg::PH_DIGITS: do_digit = 1'b1;
         aip_pkg::PH_IDLE: ;
         default: ;
      endcase

      if (do_lead) begin
         if (s1_ch_ff == aip_pkg::ChZero &&
             (number_base_ff == '0 || number_base_ff == aip_pkg::BaseHex)) begin
            base_in      = (number_base_ff == aip_pkg::BaseHex) ? aip_pkg::BaseHex
                                                                 : aip_pkg::BaseOctal;
            any_digit_in = 1'b1;
            acc_in       = '0;
            if (count_in != aip_pkg::CountMax) count_in = count_in + 1'b1;
            phase_in     = aip_pkg::PH_ZERO;
         end else begin
            base_in  = (number_base_ff == '0) ? aip_pkg::BaseDecimal : number_base_ff;
            do_digit = 1'b1;
         end
      end

      if (do_digit) begin
         if (base_in < aip_pkg::BaseMin || base_in > aip_pkg::BaseMax || digit >= base_in) begin
            emit     = 1'b1;
            phase_in = aip_pkg::PH_IDLE;
         end else begin
            if (signed_mode_ff) begin
               limit = neg_in ? aip_pkg::S64MinMag : aip_pkg::S64Max;
            end
            product = aip_pkg::ProductBits'(acc_in) * aip_pkg::ProductBits'(base_in)
                    + aip_pkg::ProductBits'(digit);
            if (ovf_in || product > aip_pkg::ProductBits'(limit)) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = product[aip_pkg::ValueBits-1:0];
            end
            any_digit_in = 1'b1;
            if (count_in != aip_pkg::CountMax) count_in = count_in + 1'b1;
            phase_in     = aip_pkg::PH_DIGITS;
         end
      end
   end

   // Result formatting. Overflow saturates; otherwise a minus sign negates modulo 2^64.
   always_comb begin
      if (ovf_in) begin
         if (!signed_mode_ff) begin
            rsp_value_in = aip_pkg::U64Max;
         end else begin
            rsp_value_in = neg_in ? aip_pkg::S64MinMag : aip_pkg::S64Max;
         end
      end else begin
         rsp_value_in = neg_in ? (aip_pkg::value_type'(0) - acc_in) : acc_in;
      end

      if (!any_digit_in) begin
         rsp_count_in = '0;
      end else if (count_in > aip_pkg::CountBits'({aip_pkg::ResultCountBits{1'b1}})) begin
         rsp_count_in = {aip_pkg::ResultCountBits{1'b1}};
      end else begin
         rsp_count_in = aip_pkg::ResultCountBits'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= aip_pkg::PH_IDLE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         count_ff     <= '0;
         any_digit_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         any_digit_ff <= any_digit_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_ovf_ff    <= ovf_in;
         rsp_digits_ff <= any_digit_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.value          = rsp_value_ff;
   assign rsp_ch.overflow       = rsp_ovf_ff;
   assign rsp_ch.digits_seen    = rsp_digits_ff;
   assign rsp_ch.consumed_count = rsp_count_ff;

   // A result without digits carries a zero value and a zero count and never overflows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_digits_ff |-> rsp_value_ff == '0 && rsp_count_ff == '0 && !rsp_ovf_ff)
      else $error("result without digits is not all zero");

   // Overflow can only be reached after a digit was taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_digits_ff)
      else $error("overflow reported without digits");

   // Once a result is produced the parser waits for the next string.
   assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> phase_ff == aip_pkg::PH_IDLE && rsp_valid_ff)
      else $error("parser did not return to idle after a result");

   // A character held by a stalled result stays in the input register.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ch_ff) && $stable(s1_first_ff))
      else $error("stalled character was lost");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for ascii_integer_parser: streams character requests, predicts
// each parse result in a behavioral model and compares every result field by field.
// Depends on aip_pkg, the channel interfaces in aip_channels.sv and the parser RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Run-length guard. In the slowest legal run every character request sits behind an
   // idle burst and a result stall. This limit leaves several times that run as margin.
   localparam int CycleLimit = 200_000;
   // A result trails its terminating character through the input and result registers.
   // Wait well past that before touching a register or ending the run.
   localparam int SettleCycles = 8;
   localparam int NoDigit = 99;
   localparam int NumPhases = 12;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharVt    = 8'h0B;
   localparam logic [7:0] CharFf    = 8'h0C;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpX   = 8'h58;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowX  = 8'h78;
   localparam logic [7:0] CharLowZ  = 8'h7A;

   localparam aip_pkg::value_type UnsignedMax = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam aip_pkg::value_type SignedMax   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam aip_pkg::value_type SignedMin   = 64'h8000_0000_0000_0000;

   // The model walks through these phases for each string. SCAN_HEX is the state
   // right after a 0x prefix, where no hex digit has been taken yet.
   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_LEAD, SCAN_SIGN, SCAN_ZERO, SCAN_HEX, SCAN_DIGITS
   } scan_phase_t;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } char_req_t;

   typedef struct packed {
      aip_pkg::value_type        value;
      logic                      overflow;
      logic                      digits_seen;
      aip_pkg::result_count_type count;
   } number_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aip_req_if req_ch ();
   aip_rsp_if rsp_ch ();
   aip_csr_if csr_ch ();

   ascii_integer_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Character requests wait here until the driver presents them.
   char_req_t pending_chars[$];
   // Expected parse results, oldest first.
   number_t   expected_numbers[$];

   int queued_chars = 0;
   int mismatches = 0;
   int cycle_count = 0;
   // One in idle_rate cycles starts an idle burst on either side. Zero turns idling off.
   int idle_rate = 8;
   int gap_left = 0;
   int stall_left = 0;

   // Register settings for each random phase. Both extremes of the base are covered, and
   // so are several invalid bases. The last phase runs with no idling at all.
   int plan_base   [NumPhases] = '{10, 0, 0, 16, 2, 36, 8, 1, 63, 37, 16, 0};
   int plan_signed [NumPhases] = '{1, 0, 1, 1, 0, 1, 0, 0, 1, 0, 0, 1};
   int plan_idle   [NumPhases] = '{8, 3, 8, 0, 8, 3, 8, 8, 8, 3, 8, 0};

   // Behavioral copy of the parser's registers and state. The model is updated when a
   // register write or a character request is accepted.
   logic [5:0]                cfg_base = 6'd10;
   logic                      cfg_signed = 1'b0;
   aip_pkg::value_type        acc = '0;
   scan_phase_t               phase = SCAN_IDLE;
   logic                      neg = 1'b0;
   logic [5:0]                radix = '0;
   aip_pkg::result_count_type nchars = '0;
   logic                      seen_digit = 1'b0;
   logic                      saturated = 1'b0;

   // The character counter sticks at its maximum.
   function automatic void bump_count();
      if (nchars != '1) begin
         nchars++;
      end
   endfunction

   // Accumulate c as a digit in the current radix. Any character that is not a digit
   // in that radix ends the number, and the function then returns 1 with the result.
   function automatic bit take_digit(input logic [7:0] c, output number_t r);
      int                 d;
      aip_pkg::value_type b;
      aip_pkg::value_type limit;
      aip_pkg::value_type cutoff;
      aip_pkg::value_type cutlim;
      r = '0;
      if (c >= CharZero && c <= CharNine) begin
         d = c - CharZero;
      end else if (c >= CharUpA && c <= CharUpZ) begin
         d = c - CharUpA + 10;
      end else if (c >= CharLowA && c <= CharLowZ) begin
         d = c - CharLowA + 10;
      end else begin
         d = NoDigit;
      end
      if (radix < 2 || radix > 36 || d >= radix) begin
         // On overflow the value saturates. Signedness is taken as it is at this moment.
         if (saturated) begin
            r.value = !cfg_signed ? UnsignedMax : (neg ? SignedMin : SignedMax);
         end else begin
            r.value = neg ? 64'd0 - acc : acc;
         end
         r.overflow = saturated;
         r.digits_seen = seen_digit;
         r.count = seen_digit ? nchars : '0;
         phase = SCAN_IDLE;
         return 1'b1;
      end
      b = radix;
      if (!cfg_signed) begin
         limit = UnsignedMax;
      end else begin
         limit = neg ? SignedMin : SignedMax;
      end
      cutoff = limit / b;
      cutlim = limit % b;
      if (saturated || acc > cutoff || (acc == cutoff && 64'(d) > cutlim)) begin
         saturated = 1'b1;
      end else begin
         acc = acc * b + 64'(d);
      end
      seen_digit = 1'b1;
      bump_count();
      phase = SCAN_DIGITS;
      return 1'b0;
   endfunction

   // Advance the parser model by one accepted character. Returns 1 when the character
   // ends a number, and the expected result is then returned in r.
   function automatic bit scan_char(input logic [7:0] c, input logic f, output number_t r);
      r = '0;
      // A first flag always opens a new string, and a string already in progress is
      // dropped without a result.
      if (f) begin
         acc = '0;
         neg = 1'b0;
         radix = '0;
         nchars = '0;
         seen_digit = 1'b0;
         saturated = 1'b0;
         phase = SCAN_LEAD;
      end
      case (phase)
         SCAN_LEAD, SCAN_SIGN: begin
            if (phase == SCAN_LEAD && (c == CharSpace || (c >= CharTab && c <= CharCr))) begin
               bump_count();
               return 1'b0;
            end
            if (phase == SCAN_LEAD && (c == CharMinus || c == CharPlus)) begin
               neg = (c == CharMinus);
               bump_count();
               phase = SCAN_SIGN;
               return 1'b0;
            end
            // A leading zero counts as a digit. In base 0 it selects octal unless an x
            // follows.
            if (c == CharZero && (cfg_base == 6'd0 || cfg_base == 6'd16)) begin
               radix = (cfg_base == 6'd16) ? 6'd16 : 6'd8;
               seen_digit = 1'b1;
               acc = '0;
               bump_count();
               phase = SCAN_ZERO;
               return 1'b0;
            end
            radix = (cfg_base == 6'd0) ? 6'd10 : cfg_base;
            return take_digit(c, r);
         end
         SCAN_ZERO: begin
            if (c == CharLowX || c == CharUpX) begin
               // The prefix digit stops counting as a digit until a hex digit follows.
               radix = 6'd16;
               seen_digit = 1'b0;
               bump_count();
               phase = SCAN_HEX;
               return 1'b0;
            end
            return take_digit(c, r);
         end
         SCAN_HEX, SCAN_DIGITS: begin
            return take_digit(c, r);
         end
         default: begin
            // Idle: characters without a first flag are ignored.
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_char(input logic [7:0] c, input logic f);
      pending_chars.push_back('{ch: c, first: f});
      queued_chars++;
   endtask

   // Queue a text. The first character carries the first flag when opening is set.
   // When closing is set, a NUL follows to end the string.
   task automatic queue_text(input string s, input bit opening, input bit closing);
      for (int i = 0; i < s.len(); i++) begin
         queue_char(s[i], opening && i == 0);
      end
      if (closing) begin
         queue_char(CharNul, opening && s.len() == 0);
      end
   endtask

   // Queue a literal for the current base with random content. It has
   // optional whitespace, an optional sign, an optional prefix and a random, possibly empty digit run.
   // When closing is set, the string is ended so that the parser is idle afterwards.
   task automatic queue_number(input bit closing);
      int nlead;
      int ndig;
      int b;
      int v;
      int pick;
      bit opening;
      opening = 1'b1;
      nlead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < nlead; i++) begin
         pick = $urandom_range(0, 5);
         queue_char((pick == 5) ? CharSpace : 8'(9 + pick), opening);
         opening = 1'b0;
      end
      pick = $urandom_range(0, 3);
      if (pick == 1 || pick == 2) begin
         queue_char((pick == 1) ? CharPlus : CharMinus, opening);
         opening = 1'b0;
      end
      b = (cfg_base == 6'd0) ? 10 : int'(cfg_base);
      if ((cfg_base == 6'd0 || cfg_base == 6'd16) && $urandom_range(0, 2) == 0) begin
         queue_char(CharZero, opening);
         opening = 1'b0;
         b = (cfg_base == 6'd16) ? 16 : 8;
         if ($urandom_range(0, 3) != 0) begin
            queue_char($urandom_range(0, 1) ? CharLowX : CharUpX, 1'b0);
            b = 16;
         end
      end
      // An invalid base accepts no digit, so any alphanumeric content will do.
      if (b < 2 || b > 36) begin
         b = 36;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         ndig = 0;
      end else if (pick <= 2) begin
         // Long runs that can reach the 64-bit limits in every base.
         ndig = $urandom_range(12, 70);
      end else begin
         ndig = $urandom_range(1, 8);
      end
      for (int i = 0; i < ndig; i++) begin
         v = $urandom_range(0, b - 1);
         if (v < 10) begin
            queue_char(8'(CharZero + v), opening);
         end else begin
            queue_char($urandom_range(0, 1) ? 8'(CharUpA + v - 10) : 8'(CharLowA + v - 10),
                       opening);
         end
         opening = 1'b0;
      end
      if (closing) begin
         // Sometimes a random byte comes first. When it ends the number, the NUL after it
         // arrives while the parser is idle.
         if ($urandom_range(0, 3) == 0) begin
            queue_char(8'($urandom_range(0, 255)), opening);
            opening = 1'b0;
         end
         queue_char(CharNul, opening);
      end
   endtask

   // Block until every queued request has been accepted and every expected result has
   // arrived. Then allow the parser's latency to pass. The conditions are sampled on
   // the falling edge, where nothing is changing.
   task automatic settle();
      @(negedge clock);
      while (pending_chars.size() != 0 || req_ch.valid) begin
         @(negedge clock);
      end
      while (expected_numbers.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write one register. The model takes the new value once the write is accepted.
   task automatic write_reg(input aip_pkg::csr_index_type idx, input logic [5:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         aip_pkg::CSR_NUMBER_BASE: cfg_base = data;
         aip_pkg::CSR_SIGNED_MODE: cfg_signed = data[0];
         default: ;
      endcase
   endtask

   // Request driver. A new request is presented only when the current one has been
   // taken. Random idle bursts fall between requests whenever idling is enabled.
   always @(posedge clock) begin : char_driver
      char_req_t next_char;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0 && idle_rate != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            gap_left = $urandom_range(0, 14);
            req_ch.valid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            next_char = pending_chars.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.ch <= next_char.ch;
            req_ch.first <= next_char.first;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The result side stalls in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0 && idle_rate != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
         stall_left = $urandom_range(0, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor. Every accepted request steps the model. Every accepted result is checked
   // against the oldest expected result. The request side is handled first, so a result
   // caused by the same edge would already be waiting.
   always @(posedge clock) begin : result_monitor
      number_t produced;
      number_t want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (scan_char(req_ch.ch, req_ch.first, produced)) begin
               expected_numbers.push_back(produced);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_numbers.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual value %0h",
                        $time, rsp_ch.value);
               mismatches++;
            end else begin
               want = expected_numbers.pop_front();
               check_field("value", want.value, rsp_ch.value);
               check_field("overflow", 64'(want.overflow), 64'(rsp_ch.overflow));
               check_field("digits_seen", 64'(want.digits_seen), 64'(rsp_ch.digits_seen));
               check_field("consumed_count", 64'(want.count), 64'(rsp_ch.consumed_count));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      int n;
      req_ch.valid = 1'b0;
      req_ch.ch = CharNul;
      req_ch.first = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = aip_pkg::CSR_NUMBER_BASE;
      csr_ch.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed strings, first with the reset settings: decimal and unsigned. They cover
      // the unsigned maximum and one past it, and whitespace with a minus sign that wraps
      // modulo 2^64. They also cover a string with no digits and a bare terminator.
      queue_text("18446744073709551615", 1'b1, 1'b1);
      queue_text("18446744073709551616", 1'b1, 1'b1);
      queue_text(" \t-1", 1'b1, 1'b1);
      queue_char(CharVt, 1'b1);
      queue_char(CharFf, 1'b0);
      queue_text("+42", 1'b0, 1'b1);
      queue_text("abc", 1'b1, 1'b1);
      queue_text("", 1'b1, 1'b1);
      // Restart in mid-string. After that comes a digit while idle, which must be ignored,
      // and then a non-ASCII terminator.
      queue_text("123", 1'b1, 1'b0);
      queue_text("7", 1'b1, 1'b1);
      queue_text("9", 1'b0, 1'b0);
      queue_text("5", 1'b1, 1'b0);
      queue_char(8'hC8, 1'b0);
      settle();

      // Prefix detection under signed limits. The strings are a bare 0x, exactly the
      // signed minimum, one past each signed limit, an octal literal, hex with a capital
      // X, and an octal run cut short by an 8.
      write_reg(aip_pkg::CSR_NUMBER_BASE, 6'd0);
      write_reg(aip_pkg::CSR_SIGNED_MODE, 6'd1);
      queue_text("0x", 1'b1, 1'b1);
      queue_text("-0x8000000000000000", 1'b1, 1'b1);
      queue_text("-9223372036854775809", 1'b1, 1'b1);
      queue_text("9223372036854775808", 1'b1, 1'b1);
      queue_text("0777", 1'b1, 1'b1);
      queue_text("0X1f", 1'b1, 1'b1);
      queue_text("08", 1'b1, 1'b1);
      settle();
      write_reg(aip_pkg::CSR_NUMBER_BASE, 6'd36);
      queue_text("zZ", 1'b1, 1'b1);
      queue_text("-ZZZZZZZZZZZZZZ", 1'b1, 1'b1);
      settle();
      write_reg(aip_pkg::CSR_NUMBER_BASE, 6'd1);
      queue_text("0", 1'b1, 1'b1);

      for (int p = 0; p < NumPhases; p++) begin
         settle();
         idle_rate = plan_idle[p];
         write_reg(aip_pkg::CSR_NUMBER_BASE, 6'(plan_base[p]));
         write_reg(aip_pkg::CSR_SIGNED_MODE, {5'($urandom_range(0, 31)), 1'(plan_signed[p])});
         target = queued_chars + 30;
         while (queued_chars < target) begin
            case ($urandom_range(0, 9))
               7: begin
                  // Random bytes, then NUL.
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) begin
                     queue_char(8'($urandom_range(0, 255)), i == 0);
                  end
                  queue_char(CharNul, 1'b0);
               end
               8: begin
                  // An unfinished literal is cut off by the next string.
                  queue_number(1'b0);
                  queue_number(1'b1);
               end
               9: begin
                  // Stray characters without a first flag while the parser is idle.
                  repeat ($urandom_range(1, 3)) begin
                     pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), first: 1'b0});
                  end
                  queue_number(1'b1);
               end
               default: queue_number(1'b1);
            endcase
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
